// ===== design/gibs_pkg.sv =====
// ----------------------------------------------------------------------------
// gibs_pkg
// Shared types and constants for the greedy IoU box suppression core.
// ----------------------------------------------------------------------------
package gibs_pkg;

   localparam int CORNER_W = 18;   // Q12.5 corner with bias
   localparam int DIFF_W   = 17;   // corner difference
   localparam int AREA_W   = 34;   // product of two differences
   localparam int UNION_W  = 35;
   localparam int THR_W    = 9;
   localparam int PROD_W   = UNION_W + THR_W;
   localparam int SLOT_W   = 4;

   localparam logic [CORNER_W-1:0] CORNER_BIAS     = 18'h10000;
   localparam logic [THR_W-1:0]    THRESHOLD_RESET = 9'd128;

   typedef struct packed {
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [15:0] box_width;
      logic [15:0] box_height;
      logic        frame_start;
   } req_type;

   typedef struct packed {
      logic              kept;
      logic [SLOT_W-1:0] slot;
      logic              table_full;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture the accepted box, clear the hit flag
      logic rd_en;    // read one kept slot into the compare pipe
      logic commit;   // store the current box in the table
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic busy;     // compare pipe still holds beats
      logic hit;      // some kept box overlapped beyond the threshold
   } status_type;

endpackage

// ===== design/greedy_iou_box_suppression_core.sv =====
// ----------------------------------------------------------------------------
// greedy_iou_box_suppression_core
// Greedy non-maximum suppression of score-sorted boxes by IoU threshold.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one candidate box per beat (center, size in Q12.4, and
//   frame_start, which empties the kept table before the box is handled).
//   Boxes must arrive sorted by descending score.
//   rsp_* returns one beat per box: kept with its slot, or table_full when
//   the box survived but the table had no room, or all zero if suppressed.
//   csr_wr_en / csr_wr_data write the 9-bit IoU threshold (x256) when idle.
// Timing:
//   One box at a time: the kept table is swept with one read per kept box,
//   the compare pipe drains, and the response is registered on leaving the
//   decide state; the next box can be accepted in the cycle after. One
//   table read per cycle feeds a 5-stage compare pipe (min/max, areas,
//   union, threshold product, compare).
//   req_ready is high only between boxes.
// Reset: synchronous; table count goes to zero and the threshold to 128.
// Stall: the response is held in an output register until rsp_ready; the
//   next box may be accepted and swept meanwhile, and waits only to report.
// ----------------------------------------------------------------------------
module greedy_iou_box_suppression_core #(
   parameter int MAX_KEPT = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  gibs_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output gibs_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic [gibs_pkg::THR_W-1:0]        csr_wr_data
);

   localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

   gibs_pkg::cmd_type    cmd;
   gibs_pkg::status_type status;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;

   gibs_ctrl #(.MAX_KEPT(MAX_KEPT), .AW(AW)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .frame_start (req_data.frame_start),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .wr_addr     (wr_addr),
      .status      (status)
   );

   gibs_datapath #(.MAX_KEPT(MAX_KEPT), .AW(AW)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .wr_addr     (wr_addr),
      .status      (status)
   );

endmodule

// ===== design/gibs_ram.sv =====
// ----------------------------------------------------------------------------
// gibs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gibs_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/gibs_datapath.sv =====
// ----------------------------------------------------------------------------
// gibs_datapath
// Corner conversion, kept-box table and the pipelined IoU compare.
// ----------------------------------------------------------------------------
module gibs_datapath #(
   parameter int MAX_KEPT = 16,
   parameter int AW       = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gibs_pkg::req_type             req_data,
   input  logic                          csr_wr_en,
   input  logic [gibs_pkg::THR_W-1:0]    csr_wr_data,
   input  gibs_pkg::cmd_type             cmd,
   input  logic [AW-1:0]                 rd_addr,
   input  logic [AW-1:0]                 wr_addr,
   output gibs_pkg::status_type          status
);

   localparam int CW = gibs_pkg::CORNER_W;
   localparam int DW = gibs_pkg::DIFF_W;
   localparam int AR = gibs_pkg::AREA_W;
   localparam int UW = gibs_pkg::UNION_W;
   localparam int PW = gibs_pkg::PROD_W;

   logic [gibs_pkg::THR_W-1:0] thr_ff;

   // current box
   logic [CW-1:0] left_ff, right_ff, top_ff, bottom_ff;
   logic [AR-1:0] area_new_ff;
   logic [CW-1:0] left_in, right_in, top_in, bottom_in;
   logic [AR-1:0] area_new_in;

   // table read data
   logic [2*CW-1:0] horz_rd, vert_rd;
   logic [CW-1:0]   kl, kr, kt, kb;

   // pipe
   logic          v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic          ov2_ff, ov3_ff, ov4_ff, ov5_ff;
   logic [DW-1:0] dx_ff, dy_ff, kdx_ff, kdy_ff;
   logic [AR-1:0] inter3_ff, akept3_ff, inter4_ff, inter5_ff;
   logic [UW-1:0] uni4_ff;
   logic [PW-1:0] prod5_ff;
   logic          hit_ff;

   logic [CW-1:0] il, ir, it, ib;
   logic          ov_in;
   logic [CW-1:0] dx_full, dy_full, kdx_full, kdy_full;
   logic [PW-1:0] inter_scaled;

   always_comb begin
      left_in   = {1'b0, req_data.center_x, 1'b0} + gibs_pkg::CORNER_BIAS
                  - {2'b00, req_data.box_width};
      right_in  = {1'b0, req_data.center_x, 1'b0} + gibs_pkg::CORNER_BIAS
                  + {2'b00, req_data.box_width};
      top_in    = {1'b0, req_data.center_y, 1'b0} + gibs_pkg::CORNER_BIAS
                  - {2'b00, req_data.box_height};
      bottom_in = {1'b0, req_data.center_y, 1'b0} + gibs_pkg::CORNER_BIAS
                  + {2'b00, req_data.box_height};
      // (2w)*(2h)
      area_new_in = {(AR-2)'(req_data.box_width * req_data.box_height), 2'b00};
   end

   gibs_ram #(.WIDTH(2*CW), .DEPTH(MAX_KEPT)) u_horz (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (wr_addr),
      .wr_data ({right_ff, left_ff}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (horz_rd)
   );

   gibs_ram #(.WIDTH(2*CW), .DEPTH(MAX_KEPT)) u_vert (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (wr_addr),
      .wr_data ({bottom_ff, top_ff}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (vert_rd)
   );

   assign kl = horz_rd[CW-1:0];
   assign kr = horz_rd[2*CW-1:CW];
   assign kt = vert_rd[CW-1:0];
   assign kb = vert_rd[2*CW-1:CW];

   always_comb begin
      il       = (left_ff   > kl) ? left_ff   : kl;
      ir       = (right_ff  < kr) ? right_ff  : kr;
      it       = (top_ff    > kt) ? top_ff    : kt;
      ib       = (bottom_ff < kb) ? bottom_ff : kb;
      ov_in    = (il < ir) && (it < ib);
      dx_full  = ir - il;
      dy_full  = ib - it;
      kdx_full = kr - kl;
      kdy_full = kb - kt;
      inter_scaled = PW'({inter5_ff, 8'h00});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= gibs_pkg::THRESHOLD_RESET;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         v1_ff <= cmd.rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         if (cmd.load) begin
            hit_ff <= 1'b0;
         end else if (v5_ff && ov5_ff && (inter_scaled > prod5_ff)) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         left_ff     <= left_in;
         right_ff    <= right_in;
         top_ff      <= top_in;
         bottom_ff   <= bottom_in;
         area_new_ff <= area_new_in;
      end
      // stage 2: overlap flag, intersection and kept-box sizes
      ov2_ff <= ov_in;
      dx_ff  <= dx_full[DW-1:0];
      dy_ff  <= dy_full[DW-1:0];
      kdx_ff <= kdx_full[DW-1:0];
      kdy_ff <= kdy_full[DW-1:0];
      // stage 3: areas
      ov3_ff    <= ov2_ff;
      inter3_ff <= dx_ff * dy_ff;
      akept3_ff <= kdx_ff * kdy_ff;
      // stage 4: union
      ov4_ff    <= ov3_ff;
      inter4_ff <= inter3_ff;
      uni4_ff   <= UW'(area_new_ff) + UW'(akept3_ff) - UW'(inter3_ff);
      // stage 5: threshold times union
      ov5_ff    <= ov4_ff;
      inter5_ff <= inter4_ff;
      prod5_ff  <= thr_ff * uni4_ff;
   end

   assign status.busy = v1_ff | v2_ff | v3_ff | v4_ff | v5_ff;
   assign status.hit  = hit_ff;

endmodule

// ===== design/gibs_ctrl.sv =====
// ----------------------------------------------------------------------------
// gibs_ctrl
// Sequencer: accepts a box, sweeps the kept table, decides and reports.
// ----------------------------------------------------------------------------
module gibs_ctrl #(
   parameter int MAX_KEPT = 16,
   parameter int AW       = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  frame_start,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gibs_pkg::rsp_type     rsp_data,
   output gibs_pkg::cmd_type     cmd,
   output logic [AW-1:0]         rd_addr,
   output logic [AW-1:0]         wr_addr,
   input  gibs_pkg::status_type  status
);

   localparam int CNT_W = $clog2(MAX_KEPT + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   gibs_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              out_free;
   logic              has_room;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign has_room = count_ff < CNT_W'(MAX_KEPT);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               if (frame_start) begin
                  count_in = '0;
               end
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (idx_ff < count_ff) begin
               cmd.rd_en = 1'b1;
               idx_in    = idx_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (!status.hit) begin
                  if (has_room) begin
                     cmd.commit       = 1'b1;
                     rsp_data_in.kept = 1'b1;
                     rsp_data_in.slot = gibs_pkg::SLOT_W'(count_ff);
                     count_in         = count_ff + 1'b1;
                  end else begin
                     rsp_data_in.table_full = 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rd_addr   = idx_ff[AW-1:0];
   assign wr_addr   = count_ff[AW-1:0];

endmodule

// ===== tb/suppression_check_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// suppression_check_pkg
// Scoreboard for the greedy IoU box suppression core: keeps its own table of
// kept boxes, works out the verdict for every accepted box and compares each
// response beat against the oldest outstanding verdict.
// ----------------------------------------------------------------------------
package suppression_check_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int CW          = gibs_pkg::CORNER_W;
   localparam int TW          = gibs_pkg::THR_W;

   class suppression_scoreboard;
      bit [2*CW-1:0]     span_x [TABLE_DEPTH];   // right : left
      bit [2*CW-1:0]     span_y [TABLE_DEPTH];   // bottom : top
      bit [4:0]          kept_total;
      bit [TW-1:0]       iou_limit;
      gibs_pkg::rsp_type expected_verdicts [$];
      int unsigned       error_count;

      function new();
         kept_total  = '0;
         iou_limit   = gibs_pkg::THRESHOLD_RESET;
         error_count = 0;
      endfunction

      function void set_iou_limit(bit [TW-1:0] value);
         iou_limit = value;
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction

      function bit overlap_exceeds(bit [CW-1:0] lo_x, bit [CW-1:0] hi_x,
                                   bit [CW-1:0] lo_y, bit [CW-1:0] hi_y,
                                   int idx);
         bit [CW-1:0]     kl, kr, kt, kb, cl, cr, ct, cb;
         longint unsigned shared, area_new, area_kept, joint;
         kl = span_x[idx][CW-1:0];
         kr = span_x[idx][2*CW-1:CW];
         kt = span_y[idx][CW-1:0];
         kb = span_y[idx][2*CW-1:CW];
         cl = (lo_x > kl) ? lo_x : kl;
         cr = (hi_x < kr) ? hi_x : kr;
         ct = (lo_y > kt) ? lo_y : kt;
         cb = (hi_y < kb) ? hi_y : kb;
         // touching or disjoint boxes count as zero IoU
         if (!(cl < cr && ct < cb))
            return 1'b0;
         shared    = longint'(cr - cl) * longint'(cb - ct);
         area_new  = longint'(hi_x - lo_x) * longint'(hi_y - lo_y);
         area_kept = longint'(kr - kl) * longint'(kb - kt);
         joint     = area_new + area_kept - shared;
         return shared * 256 > longint'(iou_limit) * joint;
      endfunction

      function gibs_pkg::rsp_type predict_verdict(gibs_pkg::req_type box);
         gibs_pkg::rsp_type verdict;
         bit [CW-1:0]       lo_x, hi_x, lo_y, hi_y;
         bit                survives;
         verdict  = '0;
         survives = 1'b1;
         if (box.frame_start)
            kept_total = '0;
         lo_x = CW'(2 * int'(box.center_x) + int'(gibs_pkg::CORNER_BIAS)
                    - int'(box.box_width));
         hi_x = CW'(2 * int'(box.center_x) + int'(gibs_pkg::CORNER_BIAS)
                    + int'(box.box_width));
         lo_y = CW'(2 * int'(box.center_y) + int'(gibs_pkg::CORNER_BIAS)
                    - int'(box.box_height));
         hi_y = CW'(2 * int'(box.center_y) + int'(gibs_pkg::CORNER_BIAS)
                    + int'(box.box_height));
         for (int i = 0; i < int'(kept_total); i++) begin
            if (overlap_exceeds(lo_x, hi_x, lo_y, hi_y, i)) begin
               survives = 1'b0;
               break;
            end
         end
         if (survives) begin
            if (kept_total < TABLE_DEPTH) begin
               span_x[kept_total] = {hi_x, lo_x};
               span_y[kept_total] = {hi_y, lo_y};
               verdict.kept = 1'b1;
               verdict.slot = kept_total[gibs_pkg::SLOT_W-1:0];
               kept_total++;
            end else begin
               verdict.table_full = 1'b1;
            end
         end
         return verdict;
      endfunction

      function void note_box(gibs_pkg::req_type box);
         expected_verdicts = {expected_verdicts, predict_verdict(box)};
      endfunction

      function void check_result(gibs_pkg::rsp_type got);
         gibs_pkg::rsp_type want;
         if (expected_verdicts.size() == 0) begin
            $error("response beat with no box outstanding: kept=%0b slot=%0d table_full=%0b",
                   got.kept, got.slot, got.table_full);
            error_count++;
            return;
         end
         want = expected_verdicts.pop_front();
         if (got.kept !== want.kept) begin
            $error("kept: expected %0b, got %0b", want.kept, got.kept);
            error_count++;
         end
         if (got.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
            error_count++;
         end
         if (got.table_full !== want.table_full) begin
            $error("table_full: expected %0b, got %0b", want.table_full, got.table_full);
            error_count++;
         end
      endfunction
   endclass

endpackage

// ===== tb/greedy_iou_box_suppression_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_iou_box_suppression_core_tb
// Drives candidate boxes through the suppression core: a directed set for
// the corner cases (identical, disjoint and zero-size boxes, extreme fields,
// threshold 0 and 256, a full table), then framed random boxes under several
// thresholds and idle patterns, with one long response stall. Every response
// beat is checked by the scoreboard.
// ----------------------------------------------------------------------------
module greedy_iou_box_suppression_core_tb;

   localparam int CLOCK_PERIOD     = 12;
   localparam int RUN_LIMIT_CYCLES = 600_000;
   localparam int RANDOM_PHASES    = 9;
   localparam int BOXES_PER_PHASE  = 100;
   localparam int STALL_PHASE      = 6;
   localparam int TABLE_DEPTH      = suppression_check_pkg::TABLE_DEPTH;
   localparam int THR_W            = gibs_pkg::THR_W;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   gibs_pkg::req_type req_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   gibs_pkg::rsp_type rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [THR_W-1:0]  csr_wr_data = '0;

   suppression_check_pkg::suppression_scoreboard sb = new();

   gibs_pkg::req_type pending_boxes [$];
   gibs_pkg::req_type frame_history [$];
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                hold_left     = 0;

   greedy_iou_box_suppression_core #(
      .MAX_KEPT(TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en)
            sb.set_iou_limit(csr_wr_data);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_data);
         if (req_valid && req_ready)
            sb.note_box(req_data);
      end
   end

   // response side: random backpressure, or a counted hold-off on request
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      #(RUN_LIMIT_CYCLES * CLOCK_PERIOD);
      $display("greedy_iou_box_suppression_core_tb: done, errors");
      $finish;
   end

   function automatic gibs_pkg::req_type box_at(int cx, int cy, int w, int h, bit fs);
      gibs_pkg::req_type box;
      box.center_x    = 16'(cx);
      box.center_y    = 16'(cy);
      box.box_width   = 16'(w);
      box.box_height  = 16'(h);
      box.frame_start = fs;
      return box;
   endfunction

   function automatic void enqueue_box(gibs_pkg::req_type box);
      pending_boxes = {pending_boxes, box};
   endfunction

   function automatic logic [15:0] nudge(logic [15:0] v, int spread);
      return 16'(int'(v) + int'($urandom_range(2 * spread)) - spread);
   endfunction

   // up to half of the boxes are variations of earlier ones in the frame so IoU lands
   // near the threshold; the rest are spread out, fully random or degenerate
   function automatic gibs_pkg::req_type make_candidate(bit open_frame);
      gibs_pkg::req_type cand;
      int                pick;
      int                spread;
      pick = $urandom_range(99);
      if (open_frame)
         frame_history.delete();
      if (pick < 50 && frame_history.size() > 0) begin
         spread = 16 << (2 * $urandom_range(2));
         cand = frame_history[$urandom_range(frame_history.size() - 1)];
         cand.center_x   = nudge(cand.center_x, spread);
         cand.center_y   = nudge(cand.center_y, spread);
         cand.box_width  = nudge(cand.box_width, spread);
         cand.box_height = nudge(cand.box_height, spread);
      end else if (pick < 80) begin
         cand = box_at($urandom_range(4095), $urandom_range(4095),
                       $urandom_range(2047), $urandom_range(2047), 1'b0);
      end else if (pick < 95) begin
         cand = box_at($urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
      end else begin
         cand = box_at($urandom_range(4095), $urandom_range(4095),
                       $urandom_range(1) ? 0 : $urandom_range(2047), 0, 1'b0);
         if ($urandom_range(1))
            {cand.box_width, cand.box_height} = {cand.box_height, cand.box_width};
      end
      cand.frame_start = open_frame;
      frame_history = {frame_history, cand};
      return cand;
   endfunction

   task automatic queue_random_frames(int count);
      int frame_left;
      bit open_frame;
      frame_left = 0;
      repeat (count) begin
         open_frame = 1'b0;
         if (frame_left == 0) begin
            frame_left = $urandom_range(28, 1);
            // now and then a frame runs on without its start flag
            open_frame = ($urandom_range(99) >= 5);
         end else if ($urandom_range(99) < 2) begin
            open_frame = 1'b1;
         end
         frame_left--;
         enqueue_box(make_candidate(open_frame));
      end
   endtask

   task automatic send_boxes();
      while (pending_boxes.size() > 0) begin
         if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end else begin
            req_valid <= 1'b1;
            req_data  <= pending_boxes.pop_front();
            do @(posedge clock); while (!req_ready);
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (sb.pending() > 0)
         @(posedge clock);
   endtask

   task automatic run_boxes(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      send_boxes();
      wait_drained();
   endtask

   task automatic write_iou_threshold(logic [THR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : run_sequence
      logic [THR_W-1:0] phase_limits [RANDOM_PHASES];
      phase_limits = '{9'd128, 9'd511, 9'd0, 9'd256, 9'($urandom_range(255, 1)),
                       9'd192, 9'd32, 9'd255, 9'd77};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset threshold: duplicate, disjoint, zero-size and extreme boxes
      enqueue_box(box_at(1000, 1000, 200, 200, 1'b1));
      enqueue_box(box_at(1000, 1000, 200, 200, 1'b0));
      enqueue_box(box_at(3000, 3000, 200, 200, 1'b0));
      enqueue_box(box_at(1000, 1000, 0, 0, 1'b0));
      enqueue_box(box_at(0, 0, 65535, 65535, 1'b0));
      enqueue_box(box_at(65535, 65535, 65535, 65535, 1'b0));
      enqueue_box(box_at(65535, 0, 65535, 0, 1'b0));
      run_boxes(0, 0);

      // zero threshold: any overlap suppresses
      write_iou_threshold(9'd0);
      enqueue_box(box_at(500, 500, 400, 400, 1'b1));
      enqueue_box(box_at(800, 800, 400, 400, 1'b0));
      run_boxes(0, 0);

      // threshold 256: identical boxes all survive until the table is full
      write_iou_threshold(9'd256);
      enqueue_box(box_at(2000, 2000, 300, 300, 1'b1));
      repeat (TABLE_DEPTH)
         enqueue_box(box_at(2000, 2000, 300, 300, 1'b0));
      run_boxes(0, 0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_iou_threshold(phase_limits[phase]);
         queue_random_frames(BOXES_PER_PHASE);
         if (phase == STALL_PHASE)
            hold_left = 300;
         if (phase < 3)
            run_boxes(18, 72);
         else if (phase < 6)
            run_boxes(72, 18);
         else
            run_boxes(0, 0);
      end

      repeat (40) @(posedge clock);
      if (sb.error_count == 0)
         $display("greedy_iou_box_suppression_core_tb: done, clean");
      else
         $display("greedy_iou_box_suppression_core_tb: done, errors");
      $finish;
   end

endmodule

// ===== greedy_iou_box_suppression_core.f =====
design/gibs_pkg.sv
design/gibs_ram.sv
design/gibs_datapath.sv
design/gibs_ctrl.sv
design/greedy_iou_box_suppression_core.sv
tb/suppression_check_pkg.sv
tb/greedy_iou_box_suppression_core_tb.sv
